// ----- hw/rtl/twma_pkg.sv -----
// Shared constants and types for the time-window moving average unit.
package twma_pkg;

    // Ring geometry (capacity must be a power of two)
    localparam int CAPACITY  = 1024;
    localparam int PTR_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    // Field widths
    localparam int TS_W      = 63;
    localparam int SAMPLE_W  = 32;
    localparam int SUM_W     = SAMPLE_W + PTR_W;
    localparam int ENTRY_W   = SAMPLE_W + TS_W;

    // Divider: two quotient bits per cycle
    localparam int DIV_STEPS = (SUM_W + 1) / 2;
    localparam int DIV_W     = 2 * DIV_STEPS;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    // Configuration
    localparam int           PADDR_W     = 4;
    localparam int           PDATA_W     = 64;
    localparam logic [TS_W-1:0] WINDOW_RESET = 63'd60000000000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FULL,
        S_WRITE,
        S_EV_RD,
        S_EV_CHK,
        S_DIV,
        S_DONE
    } t_state;

endpackage

// ----- hw/rtl/time_window_moving_average_unit.sv -----
// Top level of the time-window moving average unit: ring memory, eviction sequencer, output.
//
// Each request (timestamp, sample) is appended to a ring of 1024 entries held in one
// single-port-read synchronous memory; a running sum and entry count track the ring.
// A full ring first drops its oldest entry, then older entries are dropped while more
// than one remains and the new timestamp exceeds the oldest by more than window_ns.
// Result: mean = sum / count truncated toward zero, plus the count. One request is in
// flight at a time. Each window eviction costs a memory read and a compare, a full
// ring adds a drop step before the write, and when more than one entry is left at the
// end a last compare keeps the oldest entry. The divide yields two quotient bits a cycle.
// A result held by the receiver delays the next one. No clearing pass is needed after
// reset. Register window_ns sits at byte address 0 of the APB port (64-bit data, 63
// bits used) and should be written only while idle.
module time_window_moving_average_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Input requests
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [twma_pkg::TS_W-1:0]            i_timestamp_ns,
    input  logic signed [twma_pkg::SAMPLE_W-1:0] i_sample,
    // Results
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [twma_pkg::SAMPLE_W-1:0] o_mean,
    output logic [10:0]                          o_samples_in_window,
    // Configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [twma_pkg::PADDR_W-1:0]         paddr,
    input  logic [twma_pkg::PDATA_W-1:0]         pwdata,
    output logic [twma_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready
);

    twma_pkg::t_state                    r_state, n_state;
    logic [twma_pkg::TS_W-1:0]           r_window;
    logic [twma_pkg::PTR_W-1:0]          r_wp, n_wp;
    logic [twma_pkg::CNT_W-1:0]          r_cnt, n_cnt;
    logic signed [twma_pkg::SUM_W-1:0]   r_sum, n_sum;
    logic [twma_pkg::TS_W-1:0]           r_ts;
    logic signed [twma_pkg::SAMPLE_W-1:0] r_x;
    logic                                r_out_valid, n_out_valid;
    logic signed [twma_pkg::SAMPLE_W-1:0] r_mean;
    logic [10:0]                         r_out_cnt;
    logic signed [twma_pkg::SAMPLE_W-1:0] r_q;

    // Ring memory: {sample, timestamp}
    logic [twma_pkg::ENTRY_W-1:0]        r_mem [twma_pkg::CAPACITY];
    logic [twma_pkg::ENTRY_W-1:0]        r_rd_data;
    logic [twma_pkg::PTR_W-1:0]          rd_addr;
    logic                                mem_we;

    logic                                accept;
    logic                                out_take;
    logic                                div_start;
    logic                                div_busy;
    logic                                div_done;
    logic signed [twma_pkg::SAMPLE_W-1:0] div_q;
    logic [twma_pkg::TS_W-1:0]           old_ts;
    logic signed [twma_pkg::SAMPLE_W-1:0] old_val;
    logic [twma_pkg::TS_W-1:0]           ts_diff;
    logic                                evict;
    logic                                cfg_wr;

    assign accept   = i_valid && o_ready;
    assign out_take = r_out_valid && i_ready;
    assign o_ready  = (r_state == twma_pkg::S_IDLE);

    // Oldest slot is read every cycle; data is registered and valid in the cycle after the address settles
    assign rd_addr = r_wp - r_cnt[twma_pkg::PTR_W-1:0];
    assign mem_we  = (r_state == twma_pkg::S_WRITE);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wp] <= {r_x, r_ts};
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign old_ts  = r_rd_data[twma_pkg::TS_W-1:0];
    assign old_val = r_rd_data[twma_pkg::ENTRY_W-1:twma_pkg::TS_W];
    assign ts_diff = r_ts - old_ts;
    assign evict   = (r_ts >= old_ts) && (ts_diff > r_window);

    // Sequencer: next state and datapath updates
    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_cnt       = r_cnt;
        n_sum       = r_sum;
        n_out_valid = r_out_valid;
        div_start   = 1'b0;
        if (out_take) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            twma_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = (r_cnt == twma_pkg::CNT_W'(twma_pkg::CAPACITY)) ?
                              twma_pkg::S_FULL : twma_pkg::S_WRITE;
                end
            end
            twma_pkg::S_FULL: begin
                n_sum   = r_sum - twma_pkg::SUM_W'(old_val);
                n_cnt   = r_cnt - 1'b1;
                n_state = twma_pkg::S_WRITE;
            end
            twma_pkg::S_WRITE: begin
                n_sum   = r_sum + twma_pkg::SUM_W'(r_x);
                n_cnt   = r_cnt + 1'b1;
                n_wp    = r_wp + 1'b1;
                n_state = twma_pkg::S_EV_RD;
            end
            twma_pkg::S_EV_RD: begin
                if (r_cnt > twma_pkg::CNT_W'(1)) begin
                    n_state = twma_pkg::S_EV_CHK;
                end else begin
                    div_start = 1'b1;
                    n_state   = twma_pkg::S_DIV;
                end
            end
            twma_pkg::S_EV_CHK: begin
                if (evict) begin
                    n_sum   = r_sum - twma_pkg::SUM_W'(old_val);
                    n_cnt   = r_cnt - 1'b1;
                    n_state = twma_pkg::S_EV_RD;
                end else begin
                    div_start = 1'b1;
                    n_state   = twma_pkg::S_DIV;
                end
            end
            twma_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = twma_pkg::S_DONE;
                end
            end
            twma_pkg::S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_state     = twma_pkg::S_IDLE;
                end
            end
            default: n_state = twma_pkg::S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= twma_pkg::S_IDLE;
            r_wp        <= '0;
            r_cnt       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_cnt       <= n_cnt;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ts <= i_timestamp_ns;
            r_x  <= i_sample;
        end
        if (div_done) begin
            r_q <= div_q;
        end
        if (r_state == twma_pkg::S_DONE && (!r_out_valid || i_ready)) begin
            r_mean    <= r_q;
            r_out_cnt <= r_cnt;
        end
    end

    twma_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_cnt),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Configuration register
    assign cfg_wr = psel && penable && pwrite && pready && !paddr[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= twma_pkg::WINDOW_RESET;
        end else if (cfg_wr) begin
            r_window <= pwdata[twma_pkg::TS_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[3] ? '0 : twma_pkg::PDATA_W'(r_window);

    assign o_valid             = r_out_valid;
    assign o_mean              = r_mean;
    assign o_samples_in_window = r_out_cnt;

    // Entry count never exceeds the ring capacity
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= twma_pkg::CNT_W'(twma_pkg::CAPACITY))
        else $error("entry count above capacity");

    // A delivered result always averages at least one sample
    a_out_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_cnt != 11'd0))
        else $error("result with empty window");

    // The divider is never restarted while it is still working
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // An eviction compare only happens with more than one entry held
    a_evict_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == twma_pkg::S_EV_CHK) |-> (r_cnt > twma_pkg::CNT_W'(1)))
        else $error("eviction check with a single entry");

endmodule

// ----- hw/rtl/twma_div.sv -----
// Iterative signed-by-unsigned divider, truncating toward zero, two bits per cycle.
module twma_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [twma_pkg::SUM_W-1:0]   i_dividend,
    input  logic        [twma_pkg::CNT_W-1:0]   i_divisor,
    output logic                                o_busy,
    output logic                                o_done,
    output logic signed [twma_pkg::SAMPLE_W-1:0] o_quotient
);

    logic                              r_busy;
    logic                              r_done;
    logic [twma_pkg::STEP_W-1:0]       r_step;
    logic                              r_neg;
    logic [twma_pkg::DIV_W-1:0]        r_work;
    logic [twma_pkg::CNT_W-1:0]        r_rem;
    logic [twma_pkg::CNT_W-1:0]        r_dvs;

    logic [twma_pkg::CNT_W:0]          s1;
    logic [twma_pkg::CNT_W:0]          s2;
    logic [twma_pkg::CNT_W-1:0]        rem1;
    logic [twma_pkg::CNT_W-1:0]        rem2;
    logic                              q1;
    logic                              q2;
    logic [twma_pkg::SUM_W-1:0]        mag_in;
    logic [twma_pkg::DIV_W-1:0]        signed_q;

    // Magnitude of the dividend; the most negative value maps to 2^(SUM_W-1)
    assign mag_in = i_dividend[twma_pkg::SUM_W-1] ? (~i_dividend + 1'b1) : i_dividend;

    // Two restoring steps per cycle
    always_comb begin
        s1 = {r_rem, r_work[twma_pkg::DIV_W-1]};
        q1 = (s1 >= {1'b0, r_dvs});
        rem1 = q1 ? twma_pkg::CNT_W'(s1 - {1'b0, r_dvs}) : s1[twma_pkg::CNT_W-1:0];
        s2 = {rem1, r_work[twma_pkg::DIV_W-2]};
        q2 = (s2 >= {1'b0, r_dvs});
        rem2 = q2 ? twma_pkg::CNT_W'(s2 - {1'b0, r_dvs}) : s2[twma_pkg::CNT_W-1:0];
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_step <= twma_pkg::STEP_W'(twma_pkg::DIV_STEPS);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == twma_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend bits shift out at the top, quotient bits in at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_work <= twma_pkg::DIV_W'(mag_in);
            r_rem  <= '0;
            r_dvs  <= i_divisor;
            r_neg  <= i_dividend[twma_pkg::SUM_W-1];
        end else if (r_busy) begin
            r_work <= {r_work[twma_pkg::DIV_W-3:0], q1, q2};
            r_rem  <= rem2;
        end
    end

    assign signed_q   = r_neg ? (~r_work + 1'b1) : r_work;
    assign o_quotient = signed_q[twma_pkg::SAMPLE_W-1:0];
    assign o_busy     = r_busy;
    assign o_done     = r_done;

endmodule

// ----- verif/time_window_moving_average_unit_tb.sv -----
// Testbench for the time-window moving average unit: directed table, random phases, scoreboard.
module time_window_moving_average_unit_tb;

    localparam int HALF_PERIOD  = 10;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 64;
    localparam int LONG_HOLD    = 400;
    localparam int HOLD_AFTER   = 1300;
    localparam int PRINT_CAP    = 100;
    localparam int N_DIR        = 17;

    // Register map: window_ns is register 0 at byte 0, register 1 does not exist
    localparam logic [twma_pkg::PADDR_W-1:0] ADDR_WINDOW = twma_pkg::PADDR_W'(0);
    localparam logic [twma_pkg::PADDR_W-1:0] ADDR_NO_REG = twma_pkg::PADDR_W'(8);

    localparam logic [twma_pkg::TS_W-1:0]     TS_MAX   = '1;
    localparam logic [twma_pkg::SAMPLE_W-1:0] SMP_MAX  = 32'h7FFF_FFFF;
    localparam logic [twma_pkg::SAMPLE_W-1:0] SMP_MIN  = 32'h8000_0000;
    localparam logic [twma_pkg::SAMPLE_W-1:0] SMP_ONES = '1;

    typedef struct packed {
        logic signed [twma_pkg::SAMPLE_W-1:0] mean;
        logic [10:0]                          count;
    } t_avg_result;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind                     kind;
        logic [twma_pkg::PADDR_W-1:0]  addr;
        logic [twma_pkg::PDATA_W-1:0]  data;
        logic [twma_pkg::TS_W-1:0]     ts;
        logic [twma_pkg::SAMPLE_W-1:0] smp;
        logic                          has_exp;
        logic [twma_pkg::SAMPLE_W-1:0] mean;
        logic [10:0]                   count;
    } t_dir_row;

    // Clock and DUT ports
    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n;
    logic                                 i_valid;
    logic                                 o_ready;
    logic [twma_pkg::TS_W-1:0]            i_timestamp_ns;
    logic signed [twma_pkg::SAMPLE_W-1:0] i_sample;
    logic                                 o_valid;
    logic                                 i_ready = 1'b0;
    logic signed [twma_pkg::SAMPLE_W-1:0] o_mean;
    logic [10:0]                          o_samples_in_window;
    logic                                 psel;
    logic                                 penable;
    logic                                 pwrite;
    logic [twma_pkg::PADDR_W-1:0]         paddr;
    logic [twma_pkg::PDATA_W-1:0]         pwdata;
    logic [twma_pkg::PDATA_W-1:0]         prdata;
    logic                                 pready;

    // Shadow copy of the ring, count, sum and window
    logic signed [twma_pkg::SAMPLE_W-1:0] shadow_val [twma_pkg::CAPACITY];
    logic [twma_pkg::TS_W-1:0]            shadow_ts  [twma_pkg::CAPACITY];
    int unsigned                shadow_wr   = 0;
    int unsigned                shadow_held = 0;
    longint                     shadow_sum  = 0;
    logic [twma_pkg::TS_W-1:0]  shadow_win  = twma_pkg::WINDOW_RESET;

    t_avg_result pending_avg [$];
    t_dir_row    dir_rows [N_DIR];
    logic [twma_pkg::TS_W-1:0] last_ts = '0;

    int  cycles        = 0;
    int  mismatches    = 0;
    int  reqs_sent     = 0;
    int  results_seen  = 0;
    int  cfg_writes    = 0;
    int  full_drops    = 0;
    int  peak_fill     = 0;
    int  longest_trim  = 0;
    bit  quiet         = 1'b0;
    bit  long_hold_done = 1'b0;
    int  hold_left     = 0;
    int  stall_left    = 0;

    time_window_moving_average_unit u_dut (.*);

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // Advance the shadow ring by one request and return the mean and fill it implies
    function automatic t_avg_result window_avg_step(
            input logic [twma_pkg::TS_W-1:0] ts,
            input logic signed [twma_pkg::SAMPLE_W-1:0] smp);
        int unsigned oldest;
        int          trims;
        longint      quot;
        t_avg_result r;
        trims = 0;
        // full ring drops its oldest entry even if still inside the window
        if (shadow_held == twma_pkg::CAPACITY) begin
            oldest = (shadow_wr + twma_pkg::CAPACITY - shadow_held) % twma_pkg::CAPACITY;
            shadow_sum -= shadow_val[oldest];
            shadow_held--;
            full_drops++;
        end
        shadow_val[shadow_wr] = smp;
        shadow_ts[shadow_wr]  = ts;
        shadow_sum += smp;
        shadow_wr = (shadow_wr + 1) % twma_pkg::CAPACITY;
        shadow_held++;
        // trim entries that fell out of the window; an oldest stamp later than the new one stops the trim
        while (shadow_held > 1) begin
            oldest = (shadow_wr + twma_pkg::CAPACITY - shadow_held) % twma_pkg::CAPACITY;
            if (ts < shadow_ts[oldest])
                break;
            if (ts - shadow_ts[oldest] <= shadow_win)
                break;
            shadow_sum -= shadow_val[oldest];
            shadow_held--;
            trims++;
        end
        if (trims > longest_trim)
            longest_trim = trims;
        if (int'(shadow_held) > peak_fill)
            peak_fill = shadow_held;
        quot = shadow_sum / longint'(shadow_held);
        r.mean  = twma_pkg::SAMPLE_W'(quot);
        r.count = 11'(shadow_held);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("MISMATCH %s at cycle %0d: got 0x%0h, want 0x%0h", what, cycles, got, want);
    endtask

    // APB write followed by a readback of the window register
    task automatic set_reg(input logic [twma_pkg::PADDR_W-1:0] addr,
                           input logic [twma_pkg::PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_WINDOW)
            shadow_win = data[twma_pkg::TS_W-1:0];
        cfg_writes++;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_WINDOW;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {1'b0, shadow_win})
            report_mismatch("window readback", prdata, {1'b0, shadow_win});
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Offer one request, wait for acceptance, queue its expected result
    task automatic send_req(input logic [twma_pkg::TS_W-1:0] ts,
                            input logic [twma_pkg::SAMPLE_W-1:0] smp,
                            input bit has_exp, input t_avg_result exp_r);
        t_avg_result pred;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_timestamp_ns <= ts;
        i_sample       <= smp;
        do @(posedge i_clk); while (!o_ready);
        pred = window_avg_step(ts, smp);
        pending_avg.push_back(has_exp ? exp_r : pred);
        reqs_sent++;
        last_ts = ts;
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every queued result has come back
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending_avg.size() != 0);
    endtask

    // One window setting with a stream of mostly non-decreasing timestamps
    task automatic run_phase(input logic [twma_pkg::PDATA_W-1:0] win, input int n,
                             input longint unsigned step_max, input int jump_odds,
                             input bit mid_drain, input bit no_idle);
        logic [twma_pkg::TS_W-1:0]     ts;
        logic [twma_pkg::SAMPLE_W-1:0] smp;
        t_avg_result                   none;
        none = '0;
        drain_results();
        set_reg(ADDR_WINDOW, win);
        quiet = no_idle;
        for (int k = 0; k < n; k++) begin
            if (mid_drain && k == n / 2)
                drain_results();
            // occasional jump anywhere, which may go backwards
            if (jump_odds != 0 && $urandom_range(1, jump_odds) == 1)
                ts = twma_pkg::TS_W'({$urandom, $urandom});
            else
                ts = last_ts + twma_pkg::TS_W'({$urandom, $urandom} % (step_max + 1));
            case ($urandom_range(0, 15))
                0:       smp = SMP_MAX;
                1:       smp = SMP_MIN;
                2:       smp = '0;
                3:       smp = SMP_ONES;
                default: smp = $urandom;
            endcase
            send_req(ts, smp, 1'b0, none);
        end
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_avg_result want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (pending_avg.size() == 0) begin
                report_mismatch("result with nothing pending",
                                {21'b0, o_samples_in_window, o_mean}, 64'd0);
            end else begin
                want = pending_avg.pop_front();
                if (o_mean !== want.mean)
                    report_mismatch("mean", {32'b0, o_mean}, {32'b0, want.mean});
                if (o_samples_in_window !== want.count)
                    report_mismatch("samples_in_window", {53'b0, o_samples_in_window},
                                    {53'b0, want.count});
            end
        end
    end

    // Result-side ready: random stall bursts, one long hold-off, none in the quiet part
    always @(negedge i_clk) begin
        if (!long_hold_done && results_seen >= HOLD_AFTER) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (quiet) begin
            i_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 6);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles, pending_avg.size());
            $display("time_window_moving_average_unit_tb: done, errors");
            $finish;
        end
    end

    initial begin
        t_avg_result exp_r;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_timestamp_ns = '0;
        i_sample       = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;

        // Directed table: typed results only where obvious, the rest predicted
        dir_rows = '{
            // first request after reset, then a second equal one
            '{ROW_REQ, ADDR_WINDOW, 64'd0, 63'd0, SMP_MAX, 1'b1, SMP_MAX, 11'd1},
            '{ROW_REQ, ADDR_WINDOW, 64'd0, 63'd0, SMP_MAX, 1'b1, SMP_MAX, 11'd2},
            '{ROW_REQ, ADDR_WINDOW, 64'd0, 63'd1, SMP_MIN, 1'b0, 32'd0, 11'd0},
            // exactly at the window edge against the ts=1 entry
            '{ROW_REQ, ADDR_WINDOW, 64'd0, 63'd60000000001, SMP_ONES, 1'b0, 32'd0, 11'd0},
            // zero window: smaller stamps go, equal stamps stay
            '{ROW_CFG, ADDR_WINDOW, 64'd0, 63'd0, 32'd0, 1'b0, 32'd0, 11'd0},
            '{ROW_REQ, ADDR_WINDOW, 64'd0, 63'd60000000001, 32'd5, 1'b0, 32'd0, 11'd0},
            // timestamp going backwards keeps everything
            '{ROW_REQ, ADDR_WINDOW, 64'd0, 63'd100, 32'd3, 1'b0, 32'd0, 11'd0},
            // all-ones write, top bit must be dropped
            '{ROW_CFG, ADDR_WINDOW, 64'hFFFF_FFFF_FFFF_FFFF, 63'd0, 32'd0, 1'b0, 32'd0, 11'd0},
            '{ROW_REQ, ADDR_WINDOW, 64'd0, TS_MAX, SMP_MIN, 1'b0, 32'd0, 11'd0},
            // write to a register that does not exist is ignored
            '{ROW_CFG, ADDR_NO_REG, 64'd0, 63'd0, 32'd0, 1'b0, 32'd0, 11'd0},
            '{ROW_REQ, ADDR_WINDOW, 64'd0, TS_MAX, 32'd0, 1'b0, 32'd0, 11'd0},
            '{ROW_CFG, ADDR_WINDOW, 64'd100, 63'd0, 32'd0, 1'b0, 32'd0, 11'd0},
            '{ROW_REQ, ADDR_WINDOW, 64'd0, TS_MAX, SMP_MIN, 1'b0, 32'd0, 11'd0},
            '{ROW_REQ, ADDR_WINDOW, 64'd0, TS_MAX, SMP_MIN, 1'b0, 32'd0, 11'd0},
            '{ROW_CFG, ADDR_WINDOW, 64'd0, 63'd0, 32'd0, 1'b0, 32'd0, 11'd0},
            '{ROW_REQ, ADDR_WINDOW, 64'd0, 63'd0, 32'd1, 1'b0, 32'd0, 11'd0},
            '{ROW_CFG, ADDR_WINDOW, 64'd60000000000, 63'd0, 32'd0, 1'b0, 32'd0, 11'd0}
        };

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_DIR; r++) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                drain_results();
                set_reg(dir_rows[r].addr, dir_rows[r].data);
            end else begin
                exp_r.mean  = dir_rows[r].mean;
                exp_r.count = dir_rows[r].count;
                send_req(dir_rows[r].ts, dir_rows[r].smp, dir_rows[r].has_exp, exp_r);
            end
        end

        // widest window: fills the ring and wraps it
        run_phase(64'h7FFF_FFFF_FFFF_FFFF, 1100, 64'd1000, 0, 1'b0, 1'b0);
        // zero window right after a full ring: one long trim, then equal-stamp runs
        run_phase(64'd0, 150, 64'd2, 0, 1'b0, 1'b0);
        // narrow window with jumps; long hold-off lands here, plus a full drain midway
        run_phase(64'($urandom_range(1000, 5000)), 300, 64'd200, 32, 1'b1, 1'b0);
        // wide random window, large steps
        run_phase(64'({$urandom_range(0, 255), $urandom}), 150, 64'h4_0000_0000, 16,
                  1'b0, 1'b0);
        // reset window value, no idling on either side
        run_phase(64'd60000000000, 100, 64'd1000000000, 0, 1'b0, 1'b1);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests and %0d results over %0d register writes",
                 reqs_sent, results_seen, cfg_writes);
        $display("peak fill %0d of %0d, %0d full-ring drops, longest single trim %0d",
                 peak_fill, twma_pkg::CAPACITY, full_drops, longest_trim);
        if (mismatches == 0) begin
            $display("time_window_moving_average_unit_tb: done, clean");
        end else begin
            $display("time_window_moving_average_unit_tb: done, errors");
        end
        $finish;
    end

endmodule
